### rtl/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

	// fixed port widths
	localparam int AVAIL_W     = 10;
	localparam int AMT_PORT_W  = 8;
	localparam int CUST_PORT_W = 3;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int FIELD_KINDS = 4;

	localparam logic [AVAIL_W-1:0] AVAIL_TOP = 10'd1023;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_REQUEST = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_RUN     = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_REFUSED = 3'd1,
		STAT_UNSAFE  = 3'd2,
		STAT_HALTED  = 3'd3,
		STAT_LOADED  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SAFE,
		ST_COMMIT
	} state_t;

	// write strobes towards the customer tables
	typedef struct packed {
		logic wr_en;
		logic max_wr_en;
	} tbl_ctl_t;

	// index width for a table of n rows, never zero
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

### rtl/bankers_resource_allocator.sv
`timescale 1ns / 1ps

// banker's-style allocator: available vector plus per-customer maximum,
// allocation and need rows kept in synchronous memories
// request channel: start is taken on a rising edge while busy is low;
//   action, customer and amount_0..3 are sampled on that edge
// result channel: done is high for exactly one cycle with status and
//   avail_out_0..3; the receiver cannot stall, every result is taken
// load, request, release and any request while halted: one row read on the
//   accepting edge, one row write back in the exec state, and the result
//   registered from there; a new request may be taken once it shows
// run: the safety walk reads one customer row per cycle; an unsafe order
//   ends after the failing row, a safe one is followed by a commit walk
//   that copies maximum into allocation, clears need, one row per cycle, then halts
// configuration: cfg_valid / cfg_ready with cfg_index 0..3 loads the
//   matching available entry; cfg_ready is always high, write only idle
// reset: available, halted and all allocation and need rows clear at once;
//   maximum rows hold nothing until a load writes them
module bankers_resource_allocator #(
	parameter int NUM_CUSTOMERS = 5,
	parameter int NUM_KINDS     = 4,
	parameter int AMOUNT_BITS   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        action,
	input  logic [bra_pkg::CUST_PORT_W-1:0]   customer,
	input  logic [bra_pkg::AMT_PORT_W-1:0]    amount_0,
	input  logic [bra_pkg::AMT_PORT_W-1:0]    amount_1,
	input  logic [bra_pkg::AMT_PORT_W-1:0]    amount_2,
	input  logic [bra_pkg::AMT_PORT_W-1:0]    amount_3,
	output logic                              done,
	output logic [bra_pkg::STATUS_W-1:0]      status,
	output logic [bra_pkg::AVAIL_W-1:0]       avail_out_0,
	output logic [bra_pkg::AVAIL_W-1:0]       avail_out_1,
	output logic [bra_pkg::AVAIL_W-1:0]       avail_out_2,
	output logic [bra_pkg::AVAIL_W-1:0]       avail_out_3,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bra_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bra_pkg::AVAIL_W-1:0]       cfg_data
);

	localparam int CUST_W = bra_pkg::idx_w(NUM_CUSTOMERS);
	localparam int AB     = AMOUNT_BITS;
	localparam int NB     = AMOUNT_BITS + 1;
	localparam int VW     = bra_pkg::AVAIL_W;

	logic [bra_pkg::AMT_PORT_W-1:0] amt_p [bra_pkg::FIELD_KINDS];
	logic [VW-1:0]                  avail_p [bra_pkg::FIELD_KINDS];
	logic [NUM_KINDS*AB-1:0]        amount;
	logic [NUM_KINDS*VW-1:0]        avail;

	bra_pkg::tbl_ctl_t    tbl_ctl;
	logic [CUST_W-1:0]    rd_addr, wr_addr;
	logic [NUM_KINDS*AB-1:0] wr_alloc, max_wr_data, rd_alloc, rd_max;
	logic [NUM_KINDS*NB-1:0] wr_need, rd_need;

	assign amt_p[0] = amount_0;
	assign amt_p[1] = amount_1;
	assign amt_p[2] = amount_2;
	assign amt_p[3] = amount_3;

	// amounts trimmed to the table width; kinds without a port read zero
	for (genvar g = 0; g < NUM_KINDS; g++) begin : g_amt
		if (g < bra_pkg::FIELD_KINDS) begin : g_port
			assign amount[g*AB +: AB] = AB'(amt_p[g]);
		end else begin : g_zero
			assign amount[g*AB +: AB] = '0;
		end
	end

	// kinds beyond the configured count show zero
	for (genvar g = 0; g < bra_pkg::FIELD_KINDS; g++) begin : g_avail
		if (g < NUM_KINDS) begin : g_live
			assign avail_p[g] = avail[g*VW +: VW];
		end else begin : g_zero
			assign avail_p[g] = '0;
		end
	end

	assign avail_out_0 = avail_p[0];
	assign avail_out_1 = avail_p[1];
	assign avail_out_2 = avail_p[2];
	assign avail_out_3 = avail_p[3];

	// user sends configuration only while idle (unenforced); no back-pressure
	assign cfg_ready = 1'b1;

	bra_ctrl #(
		.NUM_CUSTOMERS (NUM_CUSTOMERS),
		.NUM_KINDS     (NUM_KINDS),
		.AMOUNT_BITS   (AMOUNT_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.customer    (customer),
		.amount      (amount),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.avail       (avail),
		.tbl_ctl     (tbl_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_alloc    (wr_alloc),
		.wr_need     (wr_need),
		.max_wr_data (max_wr_data),
		.rd_alloc    (rd_alloc),
		.rd_need     (rd_need),
		.rd_max      (rd_max)
	);

	bra_tables #(
		.NUM_CUSTOMERS (NUM_CUSTOMERS),
		.NUM_KINDS     (NUM_KINDS),
		.AMOUNT_BITS   (AMOUNT_BITS)
	) u_tables (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (tbl_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_alloc    (wr_alloc),
		.wr_need     (wr_need),
		.max_wr_data (max_wr_data),
		.rd_alloc    (rd_alloc),
		.rd_need     (rd_need),
		.rd_max      (rd_max)
	);

endmodule

### rtl/bra_tables.sv
`timescale 1ns / 1ps

module bra_tables #(
	parameter int NUM_CUSTOMERS = 5,
	parameter int NUM_KINDS     = 4,
	parameter int AMOUNT_BITS   = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  bra_pkg::tbl_ctl_t                           ctl,
	input  logic [bra_pkg::idx_w(NUM_CUSTOMERS)-1:0]    rd_addr,
	input  logic [bra_pkg::idx_w(NUM_CUSTOMERS)-1:0]    wr_addr,
	input  logic [NUM_KINDS*AMOUNT_BITS-1:0]            wr_alloc,
	input  logic [NUM_KINDS*(AMOUNT_BITS+1)-1:0]        wr_need,
	input  logic [NUM_KINDS*AMOUNT_BITS-1:0]            max_wr_data,
	output logic [NUM_KINDS*AMOUNT_BITS-1:0]            rd_alloc,
	output logic [NUM_KINDS*(AMOUNT_BITS+1)-1:0]        rd_need,
	output logic [NUM_KINDS*AMOUNT_BITS-1:0]            rd_max
);

	localparam int AW = NUM_KINDS * AMOUNT_BITS;
	localparam int NW = NUM_KINDS * (AMOUNT_BITS + 1);

	// allocation and need share a row; maximum has its own memory
	logic [AW+NW-1:0]         st_mem [NUM_CUSTOMERS];
	logic [AW-1:0]            max_mem [NUM_CUSTOMERS];
	logic [AW+NW-1:0]         st_rd_q;
	logic [AW+NW-1:0]         fwd_data_q;
	logic [AW-1:0]            max_rd_q;
	logic [NUM_CUSTOMERS-1:0] vld_q;
	logic                     rd_vld_q;
	logic                     fwd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			st_mem[wr_addr] <= {wr_alloc, wr_need};
		end
		if (ctl.max_wr_en) begin
			max_mem[wr_addr] <= max_wr_data;
		end
		st_rd_q    <= st_mem[rd_addr];
		max_rd_q   <= max_mem[rd_addr];
		fwd_data_q <= {wr_alloc, wr_need};
	end

	// row valid bits stand in for the all-zero reset of the state rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			fwd_q    <= ctl.wr_en && (wr_addr == rd_addr);
			if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// write and read of the same row on one edge: take the new data
	assign {rd_alloc, rd_need} = fwd_q ? fwd_data_q : (rd_vld_q ? st_rd_q : '0);
	assign rd_max = max_rd_q;

endmodule

### rtl/bra_ctrl.sv
`timescale 1ns / 1ps

module bra_ctrl #(
	parameter int NUM_CUSTOMERS = 5,
	parameter int NUM_KINDS     = 4,
	parameter int AMOUNT_BITS   = 8
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [1:0]                                  action,
	input  logic [bra_pkg::CUST_PORT_W-1:0]             customer,
	input  logic [NUM_KINDS*AMOUNT_BITS-1:0]            amount,
	input  logic                                        cfg_valid,
	input  logic [bra_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [bra_pkg::AVAIL_W-1:0]                 cfg_data,
	output logic                                        busy,
	output logic                                        done,
	output logic [bra_pkg::STATUS_W-1:0]                status,
	output logic [NUM_KINDS*bra_pkg::AVAIL_W-1:0]       avail,
	output bra_pkg::tbl_ctl_t                           tbl_ctl,
	output logic [bra_pkg::idx_w(NUM_CUSTOMERS)-1:0]    rd_addr,
	output logic [bra_pkg::idx_w(NUM_CUSTOMERS)-1:0]    wr_addr,
	output logic [NUM_KINDS*AMOUNT_BITS-1:0]            wr_alloc,
	output logic [NUM_KINDS*(AMOUNT_BITS+1)-1:0]        wr_need,
	output logic [NUM_KINDS*AMOUNT_BITS-1:0]            max_wr_data,
	input  logic [NUM_KINDS*AMOUNT_BITS-1:0]            rd_alloc,
	input  logic [NUM_KINDS*(AMOUNT_BITS+1)-1:0]        rd_need,
	input  logic [NUM_KINDS*AMOUNT_BITS-1:0]            rd_max
);

	localparam int CUST_W   = bra_pkg::idx_w(NUM_CUSTOMERS);
	localparam int AB       = AMOUNT_BITS;
	localparam int NB       = AMOUNT_BITS + 1;
	localparam int VW       = bra_pkg::AVAIL_W;
	localparam int CW       = ((AB > VW) ? AB : VW) + 1;
	localparam int POOL_MAX = 1023 + NUM_CUSTOMERS * ((1 << AB) - 1);
	localparam int POOL_W   = $clog2(POOL_MAX + 1);
	localparam logic [CUST_W-1:0] LAST = CUST_W'(NUM_CUSTOMERS - 1);

	bra_pkg::state_t  state_q, state_d;
	bra_pkg::action_t act_q;
	logic [CUST_W-1:0] cust_q;
	logic              cust_ok_q;
	logic [NUM_KINDS-1:0][AB-1:0]     amt_q;
	logic [NUM_KINDS-1:0][VW-1:0]     avail_q;
	logic [NUM_KINDS-1:0][POOL_W-1:0] pool_q;
	logic [CUST_W-1:0]                cnt_q;
	logic                             halted_q;
	logic                             done_q;
	logic [bra_pkg::STATUS_W-1:0]     status_q;

	logic accept, cust_ok_in, cnt_last;

	logic [NUM_KINDS-1:0][AB-1:0] rd_a, rd_m;
	logic [NUM_KINDS-1:0][NB-1:0] rd_n;

	logic [NUM_KINDS-1:0]             req_ok, rel_ok, safe_ok;
	logic [NUM_KINDS-1:0][VW-1:0]     avail_req, avail_rel, avail_fin;
	logic [NUM_KINDS-1:0][AB-1:0]     alloc_req, alloc_rel;
	logic [NUM_KINDS-1:0][NB-1:0]     need_req, need_rel, need_ld;
	logic [NUM_KINDS-1:0][POOL_W-1:0] pool_nx;

	bra_pkg::status_t             ex_status;
	logic                         ex_wr, ex_max_wr, ex_avail_wr;
	logic [NUM_KINDS-1:0][AB-1:0] ex_alloc;
	logic [NUM_KINDS-1:0][NB-1:0] ex_need;
	logic [NUM_KINDS-1:0][VW-1:0] ex_avail;

	logic                         fin_done;
	bra_pkg::status_t             fin_status;

	assign rd_a = rd_alloc;
	assign rd_n = rd_need;
	assign rd_m = rd_max;

	assign accept     = start && (state_q == bra_pkg::ST_IDLE);
	assign cust_ok_in = int'(customer) < NUM_CUSTOMERS;
	assign cnt_last   = (cnt_q == LAST);

	// per-kind arithmetic on the row just read
	always_comb begin
		logic [AB-1:0] a, m;
		logic [NB-1:0] n, asum;
		logic [CW-1:0] rsum;
		for (int k = 0; k < NUM_KINDS; k++) begin
			a    = rd_a[k];
			n    = rd_n[k];
			m    = amt_q[k];
			asum = {1'b0, a} + {1'b0, m};
			req_ok[k]    = (CW'(m) < CW'(avail_q[k])) && !asum[AB];
			rel_ok[k]    = (m <= a);
			avail_req[k] = avail_q[k] - VW'(m);
			rsum         = CW'(avail_q[k]) + CW'(m);
			avail_rel[k] = (rsum > CW'(bra_pkg::AVAIL_TOP)) ? bra_pkg::AVAIL_TOP
				: rsum[VW-1:0];
			alloc_req[k] = asum[AB-1:0];
			alloc_rel[k] = a - m;
			need_req[k]  = n - {1'b0, m};
			need_rel[k]  = n + {1'b0, m};
			need_ld[k]   = {1'b0, m};
			// negative need always fits the pool
			safe_ok[k]   = n[AB] || (POOL_W'(n[AB-1:0]) <= pool_q[k]);
			pool_nx[k]   = pool_q[k] + POOL_W'(a);
			avail_fin[k] = (pool_q[k] > POOL_W'(bra_pkg::AVAIL_TOP)) ? bra_pkg::AVAIL_TOP
				: pool_q[k][VW-1:0];
		end
	end

	// outcome of a load, request or release, and of any request while halted
	always_comb begin
		ex_status   = bra_pkg::STAT_REFUSED;
		ex_wr       = 1'b0;
		ex_max_wr   = 1'b0;
		ex_avail_wr = 1'b0;
		ex_alloc    = '0;
		ex_need     = '0;
		ex_avail    = avail_q;
		if (halted_q) begin
			ex_status = bra_pkg::STAT_HALTED;
		end else if (cust_ok_q) begin
			case (act_q)
				bra_pkg::ACT_LOAD: begin
					ex_status = bra_pkg::STAT_LOADED;
					ex_wr     = 1'b1;
					ex_max_wr = 1'b1;
					ex_need   = need_ld;
				end
				bra_pkg::ACT_REQUEST: begin
					if (&req_ok) begin
						ex_status   = bra_pkg::STAT_OK;
						ex_wr       = 1'b1;
						ex_avail_wr = 1'b1;
						ex_alloc    = alloc_req;
						ex_need     = need_req;
						ex_avail    = avail_req;
					end
				end
				bra_pkg::ACT_RELEASE: begin
					if (&rel_ok) begin
						ex_status   = bra_pkg::STAT_OK;
						ex_wr       = 1'b1;
						ex_avail_wr = 1'b1;
						ex_alloc    = alloc_rel;
						ex_need     = need_rel;
						ex_avail    = avail_rel;
					end
				end
				default: ex_status = bra_pkg::STAT_REFUSED;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bra_pkg::ST_IDLE: begin
				if (accept) begin
					if ((bra_pkg::action_t'(action) == bra_pkg::ACT_RUN) && !halted_q) begin
						state_d = bra_pkg::ST_SAFE;
					end else begin
						state_d = bra_pkg::ST_EXEC;
					end
				end
			end
			bra_pkg::ST_EXEC: state_d = bra_pkg::ST_IDLE;
			bra_pkg::ST_SAFE: begin
				if (!(&safe_ok)) begin
					state_d = bra_pkg::ST_IDLE;
				end else if (cnt_last) begin
					state_d = bra_pkg::ST_COMMIT;
				end else begin
					state_d = bra_pkg::ST_SAFE;
				end
			end
			bra_pkg::ST_COMMIT: begin
				if (cnt_last) begin
					state_d = bra_pkg::ST_IDLE;
				end
			end
			default: state_d = bra_pkg::ST_IDLE;
		endcase
	end

	// table accesses and result per state
	always_comb begin
		tbl_ctl     = '0;
		rd_addr     = '0;
		wr_addr     = cust_q;
		wr_alloc    = ex_alloc;
		wr_need     = ex_need;
		max_wr_data = amt_q;
		fin_done    = 1'b0;
		fin_status  = ex_status;
		unique case (state_q)
			bra_pkg::ST_IDLE: begin
				if ((bra_pkg::action_t'(action) != bra_pkg::ACT_RUN) && cust_ok_in) begin
					rd_addr = CUST_W'(customer);
				end
			end
			bra_pkg::ST_EXEC: begin
				tbl_ctl.wr_en     = ex_wr;
				tbl_ctl.max_wr_en = ex_max_wr;
				fin_done          = 1'b1;
			end
			bra_pkg::ST_SAFE: begin
				rd_addr = cnt_last ? '0 : cnt_q + CUST_W'(1);
				if (!(&safe_ok)) begin
					fin_done   = 1'b1;
					fin_status = bra_pkg::STAT_UNSAFE;
				end
			end
			bra_pkg::ST_COMMIT: begin
				rd_addr       = cnt_last ? '0 : cnt_q + CUST_W'(1);
				tbl_ctl.wr_en = 1'b1;
				wr_addr       = cnt_q;
				wr_alloc      = rd_m;
				wr_need       = '0;
				fin_done      = cnt_last;
				fin_status    = bra_pkg::STAT_OK;
			end
			default: fin_done = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bra_pkg::ST_IDLE;
			cnt_q    <= '0;
			halted_q <= 1'b0;
			done_q   <= 1'b0;
			status_q <= '0;
			avail_q  <= '0;
		end else begin
			state_q  <= state_d;
			done_q   <= fin_done;
			status_q <= fin_status;
			if ((state_q == bra_pkg::ST_SAFE) || (state_q == bra_pkg::ST_COMMIT)) begin
				cnt_q <= cnt_last ? '0 : cnt_q + CUST_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if ((state_q == bra_pkg::ST_COMMIT) && cnt_last) begin
				halted_q <= 1'b1;
				avail_q  <= avail_fin;
			end else if ((state_q == bra_pkg::ST_EXEC) && ex_avail_wr) begin
				avail_q <= ex_avail;
			end else if (cfg_valid) begin
				for (int k = 0; k < NUM_KINDS; k++) begin
					if ((k < bra_pkg::FIELD_KINDS) && (cfg_index == bra_pkg::CFG_IDX_W'(k))) begin
						avail_q[k] <= cfg_data;
					end
				end
			end
		end
	end

	// request capture and safety pool
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= bra_pkg::action_t'(action);
			cust_q    <= CUST_W'(customer);
			cust_ok_q <= cust_ok_in;
			amt_q     <= amount;
			for (int k = 0; k < NUM_KINDS; k++) begin
				pool_q[k] <= POOL_W'(avail_q[k]);
			end
		end else if (state_q == bra_pkg::ST_SAFE) begin
			pool_q <= pool_nx;
		end
	end

	assign busy   = (state_q != bra_pkg::ST_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign avail  = avail_q;

endmodule

### rtl/bra_checker.sv
`timescale 1ns / 1ps

module bra_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [1:0]                    action,
	input logic                          done,
	input logic [bra_pkg::STATUS_W-1:0]  status,
	input logic [bra_pkg::AVAIL_W-1:0]   avail_out_0
);

	// results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back done strobes");

	// an accepted request goes busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without busy");

	// anything but run is answered through the exec state and the registered done
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action != bra_pkg::ACT_RUN)) |-> ##2 done)
		else $error("missing result after short request");

	// a result that changes nothing leaves available entry 0 untouched
	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == bra_pkg::STAT_REFUSED) || (status == bra_pkg::STAT_UNSAFE)
			|| (status == bra_pkg::STAT_HALTED) || (status == bra_pkg::STAT_LOADED)))
		|-> $stable(avail_out_0))
		else $error("available changed on a refused or ignored request");

endmodule

bind bankers_resource_allocator bra_checker u_bra_checker (.*);
